// File: sv/sfrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfrs_pkg;

  // Fixed field widths of the result beat
  localparam int SW = 25;   // Q1.23 sample, signed
  localparam int IW = 32;   // Q8.23 input sample, signed
  localparam int OW = 11;   // count and level fields
  localparam int PW = 48;   // positions and wrapping totals
  localparam int GW = 32;   // generation count
  localparam int KW = 16;   // discard request

  localparam logic signed [IW-1:0] ONE_Q23     = IW'(32'sd8388608);
  localparam logic signed [IW-1:0] MINUS_ONE_Q23 = -ONE_Q23;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISCARD = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // Clamp a Q8.23 sample to [-1.0, +1.0] and narrow it to Q1.23
  function automatic logic signed [SW-1:0] clamp_q23(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] c;
    begin
      if (v < MINUS_ONE_Q23) begin
        c = MINUS_ONE_Q23;
      end else if (v > ONE_Q23) begin
        c = ONE_Q23;
      end else begin
        c = v;
      end
      clamp_q23 = c[SW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/stereo_frame_ring_with_stats.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo frame ring with statistics. The block takes one command beat per clock
// cycle: busy never rises, so start may be held high for a run of back-to-back
// commands (push, pop, discard, clear). Every command gives exactly one result
// beat, marked by result_valid in the cycle after the edge that took the command;
// the receiver cannot stall it, so sample it in that cycle. The result beat is
// registered to match the frame store's registered read port: a pop addresses the
// store at the accept edge and the popped frame appears on left_out/right_out
// together with the updated levels, watermarks and totals. Consecutive push and
// pop of the same slot need no interlock, since the write lands at the edge
// before the read is issued. CAPACITY must be a power of two; level fields
// are reported in 11 bits.
module stereo_frame_ring_with_stats #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      op,
  input  wire logic signed [sfrs_pkg::IW-1:0]  left_in,
  input  wire logic signed [sfrs_pkg::IW-1:0]  right_in,
  input  wire logic                            batch_last,
  input  wire logic                            fill_silence,
  input  wire logic [sfrs_pkg::KW-1:0]         discard_count,
  output logic                                 result_valid,
  output logic signed [sfrs_pkg::SW-1:0]       left_out,
  output logic signed [sfrs_pkg::SW-1:0]       right_out,
  output logic [sfrs_pkg::OW-1:0]              done_count,
  output logic [sfrs_pkg::OW-1:0]              fill_level,
  output logic [sfrs_pkg::OW-1:0]              high_mark,
  output logic [sfrs_pkg::OW-1:0]              low_mark,
  output logic [sfrs_pkg::PW-1:0]              dropped_total,
  output logic [sfrs_pkg::PW-1:0]              silent_total,
  output logic [sfrs_pkg::PW-1:0]              discarded_total,
  output logic [sfrs_pkg::PW-1:0]              written_total,
  output logic [sfrs_pkg::PW-1:0]              read_total,
  output logic [sfrs_pkg::GW-1:0]              generation_count
);
  import sfrs_pkg::*;

  localparam int AW = $clog2(CAPACITY);        // slot address
  localparam int FW = $clog2(CAPACITY + 1);    // fill level, holds CAPACITY itself
  localparam int DW = (FW > KW) ? FW : KW;     // width for the discard limit compare
  localparam logic [FW-1:0] FULL = FW'(CAPACITY);

  // Frame store: {left, right} per slot
  logic [2*SW-1:0] frame_mem [CAPACITY];
  logic [2*SW-1:0] rd_data;

  // Run state
  logic [PW-1:0] wr_pos, wr_pos_next;
  logic [PW-1:0] rd_pos, rd_pos_next;
  logic [PW-1:0] dropped, dropped_next;
  logic [PW-1:0] silent, silent_next;
  logic [PW-1:0] discarded, discarded_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] high_wm, high_wm_next;
  logic [FW-1:0] low_wm, low_wm_next;
  logic [GW-1:0] gen, gen_next;

  // Result beat registers
  logic          pop_hit, pop_hit_next;
  logic [FW-1:0] done_q, done_next;

  logic          accept;
  logic          wr_en;
  logic          rd_en;
  logic [DW-1:0] limit_n;
  logic [FW-1:0] disc_n;

  // The ring never holds back a command
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Discard at most what the ring holds
  always_comb begin
    if (DW'(discard_count) < DW'(fill)) begin
      limit_n = DW'(discard_count);
    end else begin
      limit_n = DW'(fill);
    end
    disc_n = FW'(limit_n);
  end

  always_comb begin
    wr_pos_next    = wr_pos;
    rd_pos_next    = rd_pos;
    dropped_next   = dropped;
    silent_next    = silent;
    discarded_next = discarded;
    fill_next      = fill;
    high_wm_next   = high_wm;
    low_wm_next    = low_wm;
    gen_next       = gen;
    pop_hit_next   = 1'b0;
    done_next      = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    if (accept) begin
      case (op_t'(op))
        OP_PUSH: begin
          if (fill != FULL) begin
            // store the frame and advance the write position
            wr_en       = 1'b1;
            wr_pos_next = wr_pos + PW'(1);
            fill_next   = fill + FW'(1);
            done_next   = FW'(1);
          end else begin
            // drop the frame, ring is full
            dropped_next = dropped + PW'(1);
          end
          if (batch_last) begin
            // fold the level into both watermarks at the end of a batch
            if (fill_next > high_wm) begin
              high_wm_next = fill_next;
            end
            if (fill_next < low_wm) begin
              low_wm_next = fill_next;
            end
          end
        end
        OP_POP: begin
          if (fill != '0) begin
            rd_en        = 1'b1;
            rd_pos_next  = rd_pos + PW'(1);
            fill_next    = fill - FW'(1);
            done_next    = FW'(1);
            pop_hit_next = 1'b1;
          end else if (fill_silence) begin
            // underrun: count the silence frame
            silent_next = silent + PW'(1);
          end
          if (fill_next < low_wm) begin
            low_wm_next = fill_next;
          end
        end
        OP_DISCARD: begin
          if (discard_count != '0) begin
            rd_pos_next    = rd_pos + PW'(disc_n);
            discarded_next = discarded + PW'(disc_n);
            fill_next      = fill - disc_n;
            done_next      = disc_n;
            if (fill_next < low_wm) begin
              low_wm_next = fill_next;
            end
          end
        end
        OP_CLEAR: begin
          // clear run state, keep stored frames, bump the generation
          wr_pos_next    = '0;
          rd_pos_next    = '0;
          dropped_next   = '0;
          silent_next    = '0;
          discarded_next = '0;
          fill_next      = '0;
          high_wm_next   = '0;
          low_wm_next    = FULL;
          gen_next       = gen + GW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos       <= '0;
      rd_pos       <= '0;
      dropped      <= '0;
      silent       <= '0;
      discarded    <= '0;
      fill         <= '0;
      high_wm      <= '0;
      low_wm       <= FULL;
      gen          <= GW'(1);
      pop_hit      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      wr_pos       <= wr_pos_next;
      rd_pos       <= rd_pos_next;
      dropped      <= dropped_next;
      silent       <= silent_next;
      discarded    <= discarded_next;
      fill         <= fill_next;
      high_wm      <= high_wm_next;
      low_wm       <= low_wm_next;
      gen          <= gen_next;
      pop_hit      <= pop_hit_next;
      result_valid <= accept;
    end
  end

  // Done count carries payload only; it is read under result_valid
  always_ff @(posedge clk) begin
    done_q <= done_next;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_pos[AW-1:0]] <= {clamp_q23(left_in), clamp_q23(right_in)};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= frame_mem[rd_pos[AW-1:0]];
    end
  end

  // Result beat: samples only when a pop returned a frame
  assign left_out         = pop_hit ? rd_data[2*SW-1:SW] : '0;
  assign right_out        = pop_hit ? rd_data[SW-1:0]    : '0;
  assign done_count       = OW'(done_q);
  assign fill_level       = OW'(fill);
  assign high_mark        = OW'(high_wm);
  assign low_mark         = OW'(low_wm);
  assign dropped_total    = dropped;
  assign silent_total     = silent;
  assign discarded_total  = discarded;
  assign written_total    = wr_pos;
  assign read_total       = rd_pos;
  assign generation_count = gen;

  // One result beat for every accepted command, none otherwise
  a_beat_per_cmd: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted command gave no result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !result_valid)
    else $error("result beat without a command");

  // Fill level tracks the position difference and stays within the ring
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill level above capacity");

  a_fill_pos: assert property (@(posedge clk) disable iff (rst)
    PW'(fill) == (wr_pos - rd_pos))
    else $error("fill level out of step with positions");

  // A returned frame always counts as one done frame
  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    pop_hit |-> (done_q == FW'(1)))
    else $error("popped frame without done count of one");

endmodule

`default_nettype wire

// File: tb/tb_stereo_frame_ring_with_stats.sv
`timescale 1ns / 1ps

module tb_stereo_frame_ring_with_stats;

  import sfrs_pkg::*;

  // Ring depth under test; the default size also exercises bit 10 of the levels
  localparam int RING = 1024;
  // Cycles with neither a command nor a status beat before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // Cycles to keep watching for stray status beats once nothing is owed
  localparam int TAIL_CYCLES = 8;

  // One command beat plus, for hand-checked rows, the values it must produce
  typedef struct packed {
    op_t                kind;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic               last;
    logic               silence;
    logic [15:0]        count;
    logic               known;
    logic signed [24:0] want_left;
    logic signed [24:0] want_right;
    logic [10:0]        want_done;
    logic [10:0]        want_level;
  } ring_cmd_t;

  // One status beat as the ring reports it
  typedef struct packed {
    logic signed [24:0] left;
    logic signed [24:0] right;
    logic [10:0]        done;
    logic [10:0]        level;
    logic [10:0]        peak;
    logic [10:0]        floor;
    logic [47:0]        dropped;
    logic [47:0]        silent;
    logic [47:0]        discarded;
    logic [47:0]        written;
    logic [47:0]        read;
    logic [31:0]        gen;
  } ring_status_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = 2'd0;
  logic signed [31:0] left_in = 32'sd0;
  logic signed [31:0] right_in = 32'sd0;
  logic batch_last = 1'b0;
  logic fill_silence = 1'b0;
  logic [15:0] discard_count = 16'd0;

  logic busy;
  logic result_valid;
  logic signed [24:0] left_out;
  logic signed [24:0] right_out;
  logic [10:0] done_count;
  logic [10:0] fill_level;
  logic [10:0] high_mark;
  logic [10:0] low_mark;
  logic [47:0] dropped_total;
  logic [47:0] silent_total;
  logic [47:0] discarded_total;
  logic [47:0] written_total;
  logic [47:0] read_total;
  logic [31:0] generation_count;

  stereo_frame_ring_with_stats #(
    .CAPACITY(RING)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .left_in(left_in),
    .right_in(right_in),
    .batch_last(batch_last),
    .fill_silence(fill_silence),
    .discard_count(discard_count),
    .result_valid(result_valid),
    .left_out(left_out),
    .right_out(right_out),
    .done_count(done_count),
    .fill_level(fill_level),
    .high_mark(high_mark),
    .low_mark(low_mark),
    .dropped_total(dropped_total),
    .silent_total(silent_total),
    .discarded_total(discarded_total),
    .written_total(written_total),
    .read_total(read_total),
    .generation_count(generation_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Shadow of the ring: stored frames, positions, totals and watermarks
  // ------------------------------------------------------------------
  logic signed [24:0] shadow_left [RING];
  logic signed [24:0] shadow_right [RING];
  logic [47:0] wr_count;
  logic [47:0] rd_count;
  logic [47:0] drop_count;
  logic [47:0] silence_count;
  logic [47:0] discard_sum;
  logic [10:0] peak_level;
  logic [10:0] floor_level;
  logic [31:0] gen_count;

  // Status beats the ring still owes, oldest first
  ring_status_t status_due [$];
  ring_cmd_t script [$];
  int fail_count = 0;
  int quiet_cycles = 0;

  // Clear positions, totals and watermarks; the generation is handled by the caller
  function automatic void zero_run_state();
    wr_count = '0;
    rd_count = '0;
    drop_count = '0;
    silence_count = '0;
    discard_sum = '0;
    peak_level = '0;
    floor_level = 11'(RING);
  endfunction

  // Frames held: position difference, never more than the ring depth
  function automatic logic [10:0] ring_level();
    logic [47:0] span;
    span = wr_count - rd_count;
    return (span > 48'(RING)) ? 11'(RING) : span[10:0];
  endfunction

  // Clamp a Q8.23 sample to [-1.0, +1.0] and keep it as Q1.23
  function automatic logic signed [24:0] saturate_q23(input logic signed [31:0] v);
    if (v > ONE_Q23) return 25'(ONE_Q23);
    if (v < MINUS_ONE_Q23) return 25'(MINUS_ONE_Q23);
    return v[24:0];
  endfunction

  // Apply one accepted command to the shadow and return the status beat it yields
  function automatic ring_status_t advance_ring(input ring_cmd_t c);
    ring_status_t r;
    logic [10:0] level;
    logic [15:0] n;
    int unsigned slot;
    r = '0;
    level = ring_level();
    case (c.kind)
      OP_PUSH: begin
        if (level < 11'(RING)) begin
          slot = int'(wr_count & 48'(RING - 1));
          shadow_left[slot] = saturate_q23(c.left);
          shadow_right[slot] = saturate_q23(c.right);
          wr_count = wr_count + 48'd1;
          r.done = 11'd1;
          level = level + 11'd1;
        end else begin
          drop_count = drop_count + 48'd1;
        end
        // The watermarks follow batch ends, dropped frames included
        if (c.last) begin
          if (level > peak_level) peak_level = level;
          if (level < floor_level) floor_level = level;
        end
      end
      OP_POP: begin
        if (level != 11'd0) begin
          slot = int'(rd_count & 48'(RING - 1));
          r.left = shadow_left[slot];
          r.right = shadow_right[slot];
          rd_count = rd_count + 48'd1;
          r.done = 11'd1;
          level = level - 11'd1;
        end else if (c.silence) begin
          silence_count = silence_count + 48'd1;
        end
        if (level < floor_level) floor_level = level;
      end
      OP_DISCARD: begin
        n = c.count;
        // A zero count leaves the ring and its watermarks alone
        if (n != 16'd0) begin
          if (n > 16'(level)) n = 16'(level);
          rd_count = rd_count + 48'(n);
          discard_sum = discard_sum + 48'(n);
          r.done = 11'(n);
          level = level - 11'(n);
          if (level < floor_level) floor_level = level;
        end
      end
      OP_CLEAR: begin
        zero_run_state();
        gen_count = gen_count + 32'd1;
        level = 11'd0;
      end
    endcase
    r.level = level;
    r.peak = peak_level;
    r.floor = floor_level;
    r.dropped = drop_count;
    r.silent = silence_count;
    r.discarded = discard_sum;
    r.written = wr_count;
    r.read = rd_count;
    r.gen = gen_count;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Append a directed row; known rows carry hand-read samples, done count and level
  function automatic void add_row(input op_t kind, input logic [31:0] l, input logic [31:0] r,
                                  input logic last, input logic sil, input logic [15:0] cnt,
                                  input logic known, input int wl, input int wr,
                                  input int wd, input int wf);
    ring_cmd_t c;
    c = '0;
    c.kind = kind;
    c.left = l;
    c.right = r;
    c.last = last;
    c.silence = sil;
    c.count = cnt;
    c.known = known;
    c.want_left = 25'(wl);
    c.want_right = 25'(wr);
    c.want_done = 11'(wd);
    c.want_level = 11'(wf);
    script.push_back(c);
  endfunction

  // Half the samples are anywhere in 32 bits, half sit near the clamp range
  function automatic logic [31:0] pick_sample();
    if ($urandom_range(0, 1) == 1) return $urandom;
    return 32'(int'($urandom_range(0, 16777224)) - 8388612);
  endfunction

  // Draw a command with weighted operation; unused fields carry noise too
  function automatic ring_cmd_t random_cmd(input int push_w, input int pop_w,
                                           input int discard_w, input int clear_w);
    ring_cmd_t c;
    int pick;
    c = '0;
    pick = int'($urandom_range(0, push_w + pop_w + discard_w + clear_w - 1));
    if (pick < push_w) c.kind = OP_PUSH;
    else if (pick < push_w + pop_w) c.kind = OP_POP;
    else if (pick < push_w + pop_w + discard_w) c.kind = OP_DISCARD;
    else c.kind = OP_CLEAR;
    c.left = pick_sample();
    c.right = pick_sample();
    c.last = 1'($urandom_range(0, 1));
    c.silence = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1: c.count = 16'($urandom);
      2, 3, 4: c.count = 16'($urandom_range(0, 80));
      default: c.count = 16'($urandom_range(0, 8));
    endcase
    return c;
  endfunction

  // Present one command beat, hold it until taken, then log what the ring owes
  task automatic send_beat(input ring_cmd_t c);
    ring_status_t want;
    start <= 1'b1;
    op <= c.kind;
    left_in <= c.left;
    right_in <= c.right;
    batch_last <= c.last;
    fill_silence <= c.silence;
    discard_count <= c.count;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = advance_ring(c);
    if (c.known) begin
      want.left = c.want_left;
      want.right = c.want_right;
      want.done = c.want_done;
      want.level = c.want_level;
    end
    status_due.push_back(want);
  endtask

  // Drop start for a random burst, scrambling the idle fields meanwhile
  task automatic maybe_pause(input int odds);
    if (int'($urandom_range(0, 99)) < odds) begin
      start <= 1'b0;
      op <= 2'($urandom);
      left_in <= $urandom;
      right_in <= $urandom;
      batch_last <= 1'($urandom);
      fill_silence <= 1'($urandom);
      discard_count <= 16'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // ------------------------------------------------------------------
  // Status checking and hang watchdog
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    ring_status_t want;
    if (!rst && result_valid) begin
      if (status_due.size() == 0) begin
        $display("%0t: status beat with none owed, fill_level %0d", $time, fill_level);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("left_out", want.left, left_out);
        check_field("right_out", want.right, right_out);
        check_field("done_count", want.done, done_count);
        check_field("fill_level", want.level, fill_level);
        check_field("high_mark", want.peak, high_mark);
        check_field("low_mark", want.floor, low_mark);
        check_field("dropped_total", want.dropped, dropped_total);
        check_field("silent_total", want.silent, silent_total);
        check_field("discarded_total", want.discarded, discarded_total);
        check_field("written_total", want.written, written_total);
        check_field("read_total", want.read, read_total);
        check_field("generation_count", want.gen, generation_count);
      end
    end
    // Any command or status beat counts as progress
    if ((start && !busy) || result_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_stereo_frame_ring_with_stats failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus: directed table, churn, fill to overflow, drain
  // ------------------------------------------------------------------
  initial begin
    ring_cmd_t c;
    int gap_odds;
    int overflow;
    zero_run_state();
    gen_count = 32'd1;

    // Empty ring: plain pop, silence pop, zero and oversized discards
    add_row(OP_POP,     32'h0, 32'h0, 1'b0, 1'b0, 16'd0,     1'b1, 0, 0, 0, 0);
    add_row(OP_POP,     32'h0, 32'h0, 1'b0, 1'b1, 16'd0,     1'b1, 0, 0, 0, 0);
    add_row(OP_DISCARD, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0,     1'b1, 0, 0, 0, 0);
    add_row(OP_DISCARD, 32'h0, 32'h0, 1'b0, 1'b0, 16'hFFFF,  1'b1, 0, 0, 0, 0);
    // Input extremes and both sides of the clamp points
    add_row(OP_PUSH, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0, 16'd0, 1'b1, 0, 0, 1, 1);
    add_row(OP_PUSH, 32'h00800000, 32'hFF800000, 1'b0, 1'b0, 16'd0, 1'b1, 0, 0, 1, 2);
    add_row(OP_PUSH, 32'h00800001, 32'hFF7FFFFF, 1'b0, 1'b0, 16'd0, 1'b1, 0, 0, 1, 3);
    add_row(OP_PUSH, 32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0, 16'd0, 1'b1, 0, 0, 1, 4);
    add_row(OP_PUSH, 32'h007FFFFF, 32'hFF800001, 1'b1, 1'b0, 16'd0, 1'b1, 0, 0, 1, 5);
    // Read back in order: clamped values come out as full scale
    add_row(OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 1'b1, 8388608, -8388608, 1, 4);
    add_row(OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 1'b1, 8388608, -8388608, 1, 3);
    add_row(OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 1'b1, 8388608, -8388608, 1, 2);
    add_row(OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 16'd0, 1'b1, 0, -1, 1, 1);
    // Push with stray silence and discard fields, then partial and capped discards
    add_row(OP_PUSH,    32'h12345678, 32'hEDCBA987, 1'b1, 1'b1, 16'h5A5A, 1'b0, 0, 0, 0, 0);
    add_row(OP_DISCARD, 32'h0, 32'h0, 1'b0, 1'b0, 16'd1,    1'b1, 0, 0, 1, 1);
    add_row(OP_DISCARD, 32'h0, 32'h0, 1'b1, 1'b1, 16'hFFFF, 1'b1, 0, 0, 1, 0);
    // Clear with noise on every other field
    add_row(OP_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 0, 0, 0, 0);
    add_row(OP_PUSH,  32'hAAAAAAAA, 32'h55555555, 1'b0, 1'b1, 16'd1234, 1'b0, 0, 0, 0, 0);
    add_row(OP_POP,   32'h0, 32'h0, 1'b0, 1'b1, 16'd0, 1'b0, 0, 0, 0, 0);
    add_row(OP_POP,   32'h0, 32'h0, 1'b0, 1'b1, 16'd0, 1'b1, 0, 0, 0, 0);

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    gap_odds = 20;
    foreach (script[i]) begin
      if (i > 0) maybe_pause(gap_odds);
      send_beat(script[i]);
    end

    // Churn around empty: silence pops, small discards, the odd clear
    for (int i = 0; i < 100; i++) begin
      if (i % 32 == 0) gap_odds = (i / 32 == 1) ? 0 : int'($urandom_range(5, 40));
      maybe_pause(gap_odds);
      send_beat(random_cmd(40, 35, 23, 2));
    end

    // Fill from empty until well past full so drops and a level of RING show up
    maybe_pause(gap_odds);
    send_beat(random_cmd(0, 0, 0, 1));
    overflow = 0;
    for (int i = 0; overflow < 48; i++) begin
      if (i % 64 == 0) gap_odds = (i % 192 == 64) ? 0 : int'($urandom_range(5, 40));
      c = random_cmd(97, 3, 0, 0);
      if (c.kind == OP_PUSH && ring_level() == 11'(RING)) overflow++;
      maybe_pause(gap_odds);
      send_beat(c);
    end

    // Drain with big discards and pops; the last stretch runs back to back
    for (int i = 0; i < 150; i++) begin
      if (i % 32 == 0) gap_odds = (i >= 40) ? 0 : int'($urandom_range(5, 40));
      maybe_pause(gap_odds);
      send_beat(random_cmd(20, 40, 38, 2));
    end
    start <= 1'b0;

    // Wait for every owed status beat, then keep watching for stray beats
    while (status_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_stereo_frame_ring_with_stats passed");
    end else begin
      $display("tb_stereo_frame_ring_with_stats failed");
    end
    $finish;
  end

endmodule

// File: stereo_frame_ring_with_stats.f
sv/sfrs_pkg.sv
sv/stereo_frame_ring_with_stats.sv
tb/tb_stereo_frame_ring_with_stats.sv
